// ===== rtl/r2fft_pkg.sv =====
// Package for the radix-2 FFT unit: sizes, widths, twiddle table and helpers.
// Used by r2fft_dp, r2fft_ctrl and radix2_fft_unit.
`timescale 1ns / 1ps
`default_nettype none
package r2fft_pkg;
	localparam int Points   = 64;
	localparam int AddrW    = 6;
	localparam int SampW    = 16;
	localparam int ValW     = 22;
	localparam int CntW     = 7;
	localparam int StageW   = 3;
	localparam int Stages   = AddrW;
	localparam int TwW      = 17;
	localparam int ProdW    = ValW + TwW;
	localparam int SumW     = ProdW + 1;
	localparam logic signed [ValW-1:0] ValMax = {1'b0, {(ValW-1){1'b1}}};
	localparam logic signed [ValW-1:0] ValMin = {1'b1, {(ValW-1){1'b0}}};

	typedef struct packed {
		logic signed [ValW-1:0] re;
		logic signed [ValW-1:0] im;
	} cplx_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		logic [AddrW-1:0] load_addr;
		logic             rd;       // read top/bottom pair
		logic [AddrW-1:0] top_addr;
		logic [AddrW-1:0] bot_addr;
		logic [AddrW-1:0] tw_idx;
		logic             bfly;     // butterfly inputs valid this cycle
		logic             wr;       // write butterfly results
		logic [AddrW-1:0] wr_top;
		logic [AddrW-1:0] wr_bot;
		logic             emit_rd;
		logic [AddrW-1:0] emit_addr;
	} ctl_t;

	function automatic logic signed [TwW-1:0] qcos(input logic [4:0] r);
		logic signed [TwW-1:0] v;
		case (r)
			5'd0: v = 17'sd32768;  5'd1: v = 17'sd32610;  5'd2: v = 17'sd32138;
			5'd3: v = 17'sd31357;  5'd4: v = 17'sd30274;  5'd5: v = 17'sd28899;
			5'd6: v = 17'sd27246;  5'd7: v = 17'sd25330;  5'd8: v = 17'sd23170;
			5'd9: v = 17'sd20788;  5'd10: v = 17'sd18205; 5'd11: v = 17'sd15447;
			5'd12: v = 17'sd12540; 5'd13: v = 17'sd9512;  5'd14: v = 17'sd6393;
			5'd15: v = 17'sd3212;  default: v = 17'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [TwW-1:0] cos_tab(input logic [AddrW-1:0] i);
		logic [1:0] q;
		logic [4:0] r;
		q = i[5:4];
		r = {1'b0, i[3:0]};
		case (q)
			2'd0: return qcos(r);
			2'd1: return -qcos(5'd16 - r);
			2'd2: return -qcos(r);
			default: return qcos(5'd16 - r);
		endcase
	endfunction

	function automatic logic signed [TwW-1:0] sin_tab(input logic [AddrW-1:0] i);
		return cos_tab(i - AddrW'(16));
	endfunction

	function automatic logic signed [ValW-1:0] sat(input logic signed [ValW+1:0] v);
		if (v > (ValW+2)'(ValMax)) return ValMax;
		if (v < (ValW+2)'(ValMin)) return ValMin;
		return v[ValW-1:0];
	endfunction

	function automatic logic [AddrW-1:0] bitrev(input logic [AddrW-1:0] v);
		logic [AddrW-1:0] r;
		for (int b = 0; b < AddrW; b++) r[b] = v[AddrW-1-b];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/r2fft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module r2fft_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/r2fft_dp.sv =====
// Datapath: two copies of the work store and the shared butterfly unit.
// Depends on r2fft_pkg and r2fft_ram.
`timescale 1ns / 1ps
`default_nettype none
module r2fft_dp (
	input  wire logic                          clk,
	input  wire r2fft_pkg::ctl_t               ctl,
	input  wire logic [r2fft_pkg::SampW-1:0]   in_re,
	input  wire logic [r2fft_pkg::SampW-1:0]   in_im,
	output r2fft_pkg::cplx_t                   rd_data
);
	import r2fft_pkg::*;

	cplx_t top_d, bot_d, wdata, top_res_s2, bot_res_s2, top_s1;
	logic we;
	logic [AddrW-1:0] wa, ra_top, ra_bot;
	logic signed [TwW-1:0] c_s1, s_s1;
	logic signed [ProdW-1:0] p_rc, p_is, p_rs, p_ic;
	logic signed [SumW-1:0] tr_w, ti_w;
	logic signed [ValW+1:0] tr, ti;
	logic signed [ProdW-1:0] rc_s1, is_s1, rs_s1, ic_s1;
	logic [1:0] wph_q;
	cplx_t wtop, wbot;

	// two banks, one read port each, written identically
	assign ra_top = ctl.emit_rd ? ctl.emit_addr : ctl.top_addr;
	assign ra_bot = ctl.bot_addr;
	r2fft_ram #(.Width(2*ValW), .Depth(Points)) u_bank_a (
		.clk, .we, .waddr(wa), .wdata(wdata), .raddr(ra_top), .rdata(top_d));
	r2fft_ram #(.Width(2*ValW), .Depth(Points)) u_bank_b (
		.clk, .we, .waddr(wa), .wdata(wdata), .raddr(ra_bot), .rdata(bot_d));
	assign rd_data = top_d;

	// stage 1: products of bottom by twiddle
	always_ff @(posedge clk) begin
		c_s1  <= cos_tab(ctl.tw_idx);
		s_s1  <= sin_tab(ctl.tw_idx);
	end
	always_comb begin
		p_rc = bot_d.re * c_s1;
		p_is = bot_d.im * s_s1;
		p_rs = bot_d.re * s_s1;
		p_ic = bot_d.im * c_s1;
	end
	always_ff @(posedge clk) begin
		rc_s1 <= p_rc; is_s1 <= p_is; rs_s1 <= p_rs; ic_s1 <= p_ic;
		top_s1 <= top_d;
	end

	// stage 2: round, add and subtract, saturate
	always_comb begin
		tr_w = SumW'(rc_s1) - SumW'(is_s1) + SumW'(16384);
		ti_w = SumW'(rs_s1) + SumW'(ic_s1) + SumW'(16384);
		tr = (ValW+2)'(tr_w >>> 15);
		ti = (ValW+2)'(ti_w >>> 15);
	end
	always_ff @(posedge clk) begin
		top_res_s2.re <= sat((ValW+2)'(top_s1.re) + tr);
		top_res_s2.im <= sat((ValW+2)'(top_s1.im) + ti);
		bot_res_s2.re <= sat((ValW+2)'(top_s1.re) - tr);
		bot_res_s2.im <= sat((ValW+2)'(top_s1.im) - ti);
	end

	// write: load word, else top result then bottom result
	assign wtop = top_res_s2;
	assign wbot = bot_res_s2;
	always_ff @(posedge clk) wph_q <= {ctl.wr, 1'b0};
	always_comb begin
		we = 1'b0;
		wa = ctl.load_addr;
		wdata.re = ValW'(signed'(in_re));
		wdata.im = ValW'(signed'(in_im));
		if (ctl.load) begin
			we = 1'b1;
		end else if (ctl.wr) begin
			we = 1'b1;
			wa = ctl.wr_top;
			wdata = wtop;
		end else if (wph_q[1]) begin
			we = 1'b1;
			wa = ctl.wr_bot;
			wdata = wbot;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/r2fft_ctrl.sv =====
// Controller: load counting, butterfly sequencing, and bin emission.
// Depends on r2fft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module r2fft_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_fire,
	output logic                            in_rdy,
	output r2fft_pkg::ctl_t                 ctl,
	output logic                            rd_vld,
	output logic [r2fft_pkg::AddrW-1:0]     rd_idx,
	input  wire logic                       out_free
);
	import r2fft_pkg::*;

	localparam logic [1:0] StLoad = 2'd0;
	localparam logic [1:0] StBfly = 2'd1;
	localparam logic [1:0] StEmit = 2'd2;

	// butterfly steps per pair, in order: read, multiply, sum, write top, write bottom
	localparam logic [2:0] PhLast = 3'd4;

	logic [1:0] state_q;
	logic [CntW-1:0] cnt_q;
	logic [StageW-1:0] stage_q;
	logic [AddrW-2:0] pair_q;
	logic [2:0] ph_q;
	logic [AddrW-1:0] top_a, bot_a, half, tw;
	logic emit_pend_q;
	logic [AddrW-1:0] emit_idx_q;

	// pair index j in stage s: top = (j>>s)<<(s+1) | j&(2^s-1)
	always_comb begin
		logic [AddrW-1:0] j, lowmask;
		j = {1'b0, pair_q};
		half = AddrW'(1) << stage_q;
		lowmask = half - AddrW'(1);
		top_a = ((j >> stage_q) << (stage_q + StageW'(1))) | (j & lowmask);
		bot_a = top_a | half;
		tw = (j & lowmask) << (StageW'(Stages - 1) - stage_q);
	end

	assign in_rdy = (state_q == StLoad);

	always_comb begin
		ctl = '0;
		ctl.load = in_fire;
		ctl.load_addr = bitrev(cnt_q[AddrW-1:0]);
		ctl.top_addr = top_a;
		ctl.bot_addr = bot_a;
		ctl.tw_idx = tw;
		ctl.rd = (state_q == StBfly) && (ph_q == 3'd0);
		ctl.wr = (state_q == StBfly) && (ph_q == 3'd3);
		ctl.wr_top = top_a;
		ctl.wr_bot = top_a | half;
		ctl.bfly = (state_q == StBfly) && (ph_q == 3'd1);
		ctl.emit_rd = (state_q == StEmit) && out_free && !emit_pend_q;
		ctl.emit_addr = cnt_q[AddrW-1:0];
	end

	// sequence load, butterflies and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			cnt_q <= '0;
			stage_q <= '0;
			pair_q <= '0;
			ph_q <= '0;
			emit_pend_q <= 1'b0;
			emit_idx_q <= '0;
		end else begin
			emit_pend_q <= ctl.emit_rd;
			emit_idx_q <= cnt_q[AddrW-1:0];
			unique case (state_q)
				StLoad: begin
					if (in_fire) begin
						if (cnt_q == CntW'(Points - 1)) begin
							cnt_q <= '0;
							state_q <= StBfly;
						end else begin
							cnt_q <= cnt_q + CntW'(1);
						end
					end
				end
				StBfly: begin
					if (ph_q == PhLast) begin
						ph_q <= '0;
						if (pair_q == (AddrW-1)'(Points/2 - 1)) begin
							pair_q <= '0;
							if (stage_q == StageW'(Stages - 1)) begin
								stage_q <= '0;
								state_q <= StEmit;
							end else begin
								stage_q <= stage_q + StageW'(1);
							end
						end else begin
							pair_q <= pair_q + (AddrW-1)'(1);
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				StEmit: begin
					if (ctl.emit_rd) begin
						if (cnt_q == CntW'(Points - 1)) begin
							cnt_q <= '0;
							state_q <= StLoad;
						end else begin
							cnt_q <= cnt_q + CntW'(1);
						end
					end
				end
				default: state_q <= StLoad;
			endcase
		end
	end

	assign rd_vld = emit_pend_q;
	assign rd_idx = emit_idx_q;

`ifndef ASSERT_OFF
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == StLoad) else $error("word taken while busy");
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit_rd |-> out_free) else $error("bin read with no room");
	a_ph_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q <= PhLast) else $error("phase out of range");
`endif
endmodule
`default_nettype wire

// ===== rtl/radix2_fft_unit.sv =====
// Top level of the radix-2 decimation-in-time FFT unit.
// Depends on r2fft_pkg, r2fft_ctrl, r2fft_dp and r2fft_ram.
// A frame is 64 complex Q1.15 words; they are stored in bit-reversed order as they
// arrive (one per cycle), then 192 butterflies run on one shared unit, each pair
// written back before the next pair is read, then the 64 bins leave in natural
// order (each bin is read from the store and registered before the next read
// starts), with tlast on bin 63. No input is taken during the transform or the
// emission.
`timescale 1ns / 1ps
`default_nettype none
module radix2_fft_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // sample_re[15:0], sample_im[31:16]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,  // bin_re[21:0], bin_im[43:22], bin_index[49:44]
	output logic             m_axis_tlast
);
	import r2fft_pkg::*;

	ctl_t ctl;
	cplx_t rd_data;
	logic in_fire, rd_vld, out_free;
	logic [AddrW-1:0] rd_idx;
	cplx_t bin_q;
	logic [AddrW-1:0] idx_q;
	logic vld_q;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	// room if output empty or draining, and no read already in flight
	assign out_free = (!vld_q || m_axis_tready) && !rd_vld;

	r2fft_ctrl u_ctrl (.clk, .arst_n, .in_fire, .in_rdy(s_axis_tready), .ctl,
		.rd_vld, .rd_idx, .out_free);
	r2fft_dp u_dp (.clk, .ctl, .in_re(s_axis_tdata[15:0]),
		.in_im(s_axis_tdata[31:16]), .rd_data);

	// hold output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (rd_vld) begin
			vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			vld_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (rd_vld) begin
			bin_q <= rd_data;
			idx_q <= rd_idx;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {6'd0, idx_q, bin_q.im, bin_q.re};
	assign m_axis_tlast = (idx_q == AddrW'(Points - 1));
endmodule
`default_nettype wire
